FILE: rtl/core/histogram_equalizer_unit_defines.svh
// ----------------------------------------------------------------------------
// Histogram equalizer assertion macros
// Shared concurrent assertion helpers for the histogram equalizer RTL.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_EQUALIZER_UNIT_DEFINES_SVH
`define HISTOGRAM_EQUALIZER_UNIT_DEFINES_SVH

// Implication checked every clock while out of reset.
`define HEQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define HEQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/heq_pkg.sv
// ----------------------------------------------------------------------------
// Histogram equalizer package
// Function codes, status codes and fixed widths.
// ----------------------------------------------------------------------------
package heq_pkg;
  localparam int unsigned FuncW   = 3;
  localparam int unsigned PixW    = 8;
  localparam int unsigned ValueW  = 20;
  localparam int unsigned StatusW = 2;

  localparam logic [FuncW-1:0] FuncCount    = 3'd0;
  localparam logic [FuncW-1:0] FuncFinalize = 3'd1;
  localparam logic [FuncW-1:0] FuncMap      = 3'd2;
  localparam logic [FuncW-1:0] FuncReadBin  = 3'd3;
  localparam logic [FuncW-1:0] FuncClear    = 3'd4;

  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StRange    = 2'd1;
  localparam logic [StatusW-1:0] StNotReady = 2'd2;
  localparam logic [StatusW-1:0] StFull     = 2'd3;

  // Divider control
  typedef struct packed {
    logic start;
  } div_ctl_t;
endpackage

FILE: rtl/core/histogram_equalizer_unit.sv
// ----------------------------------------------------------------------------
// Histogram equalizer unit
// Histogram counting, cumulative remap table build, pixel lookup, equalized bin read and clear.
// ----------------------------------------------------------------------------
// Command-style block: a word is taken when start_i is high and busy_o is low,
// and its single result appears on value_o/status_o for one cycle with
// done_o high; the receiver cannot stall. Count, map, read and unused codes
// keep busy_o high through the memory read, update/write and result states,
// and the result shows in the cycle after, when busy_o is already low.
// Finalize first clears the equalized store, then walks all LEVELS bins
// through one shared restoring divider of NumW = COUNT_BITS+10 bits.
// Clear sweeps the stores one bin a cycle. After reset a clearing pass over
// all LEVELS bins runs before the first word is taken; configuration writes
// are taken throughout.
`include "histogram_equalizer_unit_defines.svh"

module histogram_equalizer_unit #(
  parameter int unsigned LEVELS     = 256,
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [heq_pkg::FuncW-1:0]      func_i,
  input  logic [heq_pkg::PixW-1:0]       pixel_i,
  input  logic                           cfg_we_i,
  input  logic [heq_pkg::PixW-1:0]       cfg_wdata_i,
  output logic                           done_o,
  output logic [heq_pkg::ValueW-1:0]     value_o,
  output logic [heq_pkg::StatusW-1:0]    status_o
);
  import heq_pkg::*;

  localparam int unsigned IdxW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned NumW = COUNT_BITS + 10;  // 2*cum*max + total
  localparam int unsigned DenW = COUNT_BITS + 1;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [PixW-1:0] TopLevel = PixW'(LEVELS - 1);

  // sequencer states
  localparam logic [3:0] SInit   = 4'd0;
  localparam logic [3:0] SIdle   = 4'd1;
  localparam logic [3:0] SRd     = 4'd2;
  localparam logic [3:0] SExec   = 4'd3;
  localparam logic [3:0] SClr    = 4'd4;
  localparam logic [3:0] SFzClr  = 4'd5;
  localparam logic [3:0] SFzRd   = 4'd6;
  localparam logic [3:0] SFzDiv  = 4'd7;
  localparam logic [3:0] SFzWait = 4'd8;
  localparam logic [3:0] SFzEqRd = 4'd9;
  localparam logic [3:0] SFzEqWr = 4'd10;
  localparam logic [3:0] SDone   = 4'd11;

  // stores
  logic [COUNT_BITS-1:0] cnt_mem [LEVELS];
  logic [COUNT_BITS-1:0] eq_mem  [LEVELS];
  logic [PixW-1:0]       map_mem [LEVELS];

  logic [3:0]            st_q, st_d;
  logic [PixW-1:0]       maxl_q;
  logic [FuncW-1:0]      func_q;
  logic [PixW-1:0]       pix_q;
  logic [IdxW:0]         idx_q, idx_d;
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic [COUNT_BITS-1:0] cum_q, cum_d;
  logic [PixW-1:0]       lim_q, lim_d;
  logic                  ready_q, ready_d;
  logic [PixW-1:0]       mapv_q, mapv_d;
  logic [COUNT_BITS-1:0] bin_q, bin_d;
  logic                  done_q, done_d;
  logic [ValueW-1:0]     value_q, value_d;
  logic [StatusW-1:0]    status_q, status_d;

  // memory port controls
  logic [IdxW-1:0]       cnt_ra, eq_ra, map_ra;
  logic [COUNT_BITS-1:0] cnt_rd, eq_rd;
  logic [PixW-1:0]       map_rd;
  logic                  cnt_we, eq_we, map_we;
  logic [IdxW-1:0]       cnt_wa, eq_wa, map_wa;
  logic [COUNT_BITS-1:0] cnt_wd, eq_wd;
  logic [PixW-1:0]       map_wd;

  div_ctl_t              div_ctl;
  logic [NumW-1:0]       div_num, div_quo;
  logic                  div_done;
  logic [PixW-1:0]       lim_now;
  logic [PixW-1:0]       quo_sat;

  // divider start pulse: registered from SFzDiv, in the cycle after the cum update
  logic                  launch_q;

  assign lim_now = (maxl_q > TopLevel) ? TopLevel : maxl_q;
  assign quo_sat = (div_quo > NumW'(lim_q)) ? lim_q : div_quo[PixW-1:0];

  // 2*cum*max + total; cum register already includes the current bin
  assign div_num = NumW'({cum_q, 1'b0}) * NumW'(lim_q) + NumW'(total_q);

  heq_div #(.NumW(NumW), .DenW(DenW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .num_i  (div_num),
    .den_i  ({total_q, 1'b0}),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (eq_we)  eq_mem[eq_wa]   <= eq_wd;
    if (map_we) map_mem[map_wa] <= map_wd;
    cnt_rd <= cnt_mem[cnt_ra];
    eq_rd  <= eq_mem[eq_ra];
    map_rd <= map_mem[map_ra];
  end

  always_comb begin
    st_d     = st_q;
    idx_d    = idx_q;
    total_d  = total_q;
    cum_d    = cum_q;
    lim_d    = lim_q;
    ready_d  = ready_q;
    mapv_d   = mapv_q;
    bin_d    = bin_q;
    done_d   = 1'b0;
    value_d  = value_q;
    status_d = status_q;
    cnt_ra   = pix_q[IdxW-1:0];
    eq_ra    = pix_q[IdxW-1:0];
    map_ra   = pix_q[IdxW-1:0];
    cnt_we   = 1'b0;
    eq_we    = 1'b0;
    map_we   = 1'b0;
    cnt_wa   = pix_q[IdxW-1:0];
    eq_wa    = pix_q[IdxW-1:0];
    map_wa   = pix_q[IdxW-1:0];
    cnt_wd   = cnt_rd + 1'b1;
    eq_wd    = '0;
    map_wd   = '0;
    div_ctl.start = 1'b0;

    case (st_q)
      SInit, SClr: begin
        // zero all three stores, one bin a cycle
        cnt_we = 1'b1; eq_we = 1'b1; map_we = 1'b1;
        cnt_wa = idx_q[IdxW-1:0]; eq_wa = idx_q[IdxW-1:0];
        map_wa = idx_q[IdxW-1:0];
        cnt_wd = '0;
        idx_d  = idx_q + 1'b1;
        if (idx_q == (IdxW+1)'(LEVELS - 1)) begin
          if (st_q == SClr) begin
            st_d = SDone; value_d = '0; status_d = StOk;
          end else begin
            st_d = SIdle;
          end
        end
      end
      SIdle: begin
        if (start_i) st_d = SRd;
      end
      SRd: begin
        // store read issued with pix_q this cycle
        st_d = SExec;
        if (func_q == FuncFinalize) begin
          st_d = SFzClr; idx_d = '0; cum_d = '0; lim_d = lim_now;
        end else if (func_q == FuncClear) begin
          st_d = SClr; idx_d = '0; total_d = '0; ready_d = 1'b0;
        end
      end
      SExec: begin
        st_d     = SDone;
        value_d  = '0;
        status_d = StOk;
        case (func_q)
          FuncCount: begin
            if (pix_q > lim_now) status_d = StRange;
            else if (total_q == CountMax) status_d = StFull;
            else begin
              cnt_we  = 1'b1;
              total_d = total_q + 1'b1;
            end
          end
          FuncMap, FuncReadBin: begin
            if (!ready_q) status_d = StNotReady;
            else if (pix_q > lim_now) status_d = StRange;
            else if (func_q == FuncMap) value_d = ValueW'(map_rd);
            else value_d = ValueW'(eq_rd);
          end
          default: ;
        endcase
      end
      SFzClr: begin
        eq_we = 1'b1; eq_wa = idx_q[IdxW-1:0];
        idx_d = idx_q + 1'b1;
        if (idx_q == (IdxW+1)'(LEVELS - 1)) begin
          st_d = SFzRd; idx_d = '0;
        end
      end
      SFzRd: begin
        cnt_ra = idx_q[IdxW-1:0];
        st_d   = SFzDiv;
      end
      SFzDiv: begin
        // cnt_rd holds this bin; accumulate, then launch divide
        bin_d = cnt_rd;
        cum_d = cum_q + cnt_rd;
        st_d  = SFzWait;
      end
      SFzWait: begin
        if (div_done) begin
          mapv_d = (total_q == '0) ? '0 : quo_sat;
          st_d   = SFzEqRd;
        end
      end
      SFzEqRd: begin
        eq_ra  = IdxW'(mapv_q);
        map_we = 1'b1; map_wa = idx_q[IdxW-1:0]; map_wd = mapv_q;
        st_d   = SFzEqWr;
      end
      SFzEqWr: begin
        eq_we = 1'b1; eq_wa = IdxW'(mapv_q); eq_wd = eq_rd + bin_q;
        idx_d = idx_q + 1'b1;
        if (idx_q == (IdxW+1)'(LEVELS - 1)) begin
          st_d = SDone; ready_d = 1'b1; value_d = '0; status_d = StOk;
        end else begin
          st_d = SFzRd;
        end
      end
      SDone: begin
        done_d = 1'b1;
        st_d   = SIdle;
      end
      default: st_d = SIdle;
    endcase
    // launch the divide on entry to the wait state
    if (st_q == SFzWait && launch_q) div_ctl.start = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) launch_q <= 1'b0;
    else launch_q <= (st_q == SFzDiv);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= SInit;
      idx_q    <= '0;
      total_q  <= '0;
      ready_q  <= 1'b0;
      maxl_q   <= 8'd255;
      done_q   <= 1'b0;
    end else begin
      st_q     <= st_d;
      idx_q    <= idx_d;
      total_q  <= total_d;
      ready_q  <= ready_d;
      done_q   <= done_d;
      if (cfg_we_i) maxl_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cum_q    <= cum_d;
    lim_q    <= lim_d;
    mapv_q   <= mapv_d;
    bin_q    <= bin_d;
    value_q  <= value_d;
    status_q <= status_d;
    if (st_q == SIdle && start_i) begin
      func_q <= func_i;
      pix_q  <= pixel_i;
    end
  end

  assign busy_o   = (st_q != SIdle);
  assign done_o   = done_q;
  assign value_o  = done_q ? value_q : '0;
  assign status_o = done_q ? status_q : StOk;

  `HEQ_ASSERT_NXT(a_take_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `HEQ_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy_o)
  `HEQ_ASSERT_IMP(a_total_cap, clk_i, rst_ni, status_o == StFull && done_o,
    total_q == CountMax)
endmodule

FILE: rtl/core/heq_div.sv
// ----------------------------------------------------------------------------
// Histogram equalizer divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module heq_div #(
  parameter int unsigned NumW = 30,
  parameter int unsigned DenW = 21
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  heq_pkg::div_ctl_t   ctl_i,
  input  logic [NumW-1:0]     num_i,
  input  logic [DenW-1:0]     den_i,
  output logic                done_o,
  output logic [NumW-1:0]     quo_o
);
  import heq_pkg::*;

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (ctl_i.start) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = CntW'(NumW);
      run_d = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule
